FILE: hw/rtl/rthsv_pkg.sv
// Package with the widths, pipeline types and divider step shared by the RGB to HSV converter.
`timescale 1ns / 1ps

package rthsv_pkg;

  // Width of one color component.
  localparam int CompBits = 8;
  // Divisor holds up to six times the chroma.
  localparam int DivBits = CompBits + 3;
  // A shifted partial remainder stays below twice the divisor.
  localparam int RemBits = CompBits + 4;
  // Hue and saturation quotients are both 16 bits.
  localparam int QuoBits = 16;
  // Quotient bits resolved in each divider stage.
  localparam int StepsPerStage = 4;
  localparam int DivStages = QuoBits / StepsPerStage;
  // Saturation of one.
  localparam logic [QuoBits-1:0] SatOne = 16'd32768;

  // One long division in flight.
  typedef struct packed {
    logic [RemBits-1:0] rem;
    logic [DivBits-1:0] divisor;
    logic [QuoBits-1:0] quo;
  } div_lane_t;

  // Payload carried down the pipeline.
  typedef struct packed {
    div_lane_t           hue;
    div_lane_t           sat;
    logic [CompBits-1:0] bright;
  } stage_t;

  // Resolve StepsPerStage quotient bits by restoring division.
  function automatic div_lane_t div_step(input div_lane_t lane_in);
    div_lane_t          lane;
    logic [RemBits-1:0] rem_sh;
    lane = lane_in;
    for (int i = 0; i < StepsPerStage; i++) begin
      rem_sh = lane.rem << 1;
      if (rem_sh >= {1'b0, lane.divisor}) begin
        lane.rem = rem_sh - {1'b0, lane.divisor};
        lane.quo = {lane.quo[QuoBits-2:0], 1'b1};
      end else begin
        lane.rem = rem_sh;
        lane.quo = {lane.quo[QuoBits-2:0], 1'b0};
      end
    end
    return lane;
  endfunction

endpackage

FILE: hw/rtl/rgb_to_hsv_converter_top.sv
// A result is on the out_ ports for one cycle, from the last divider stage register.
// Throughput: one pixel per cycle; busy is always low, the pipeline never stalls.
// Depth is set by one preparation stage and four divider stages, each resolving
// four quotient bits of the hue and saturation divisions.
// Reset: synchronous, active low; it clears the valid bits of every stage.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top
  import rthsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CompBits-1:0] in_red,
  input  logic [CompBits-1:0] in_green,
  input  logic [CompBits-1:0] in_blue,
  output logic                out_valid,
  output logic [QuoBits-1:0]  out_hue,
  output logic [QuoBits-1:0]  out_saturation,
  output logic [CompBits-1:0] out_brightness
);

  logic   vld [0:DivStages];
  stage_t stg [0:DivStages];

  // The pipeline takes a transaction every cycle.
  assign busy = 1'b0;

  // Preparation stage.
  rthsv_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .valid_r  (vld[0]),
    .stage_r  (stg[0])
  );

  // Divider stages.
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    rthsv_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (vld[k]),
      .stage_in (stg[k]),
      .valid_r  (vld[k+1]),
      .stage_r  (stg[k+1])
    );
  end

  // Results come straight from the last stage register.
  assign out_valid      = vld[DivStages];
  assign out_hue        = stg[DivStages].hue.quo;
  assign out_saturation = stg[DivStages].sat.quo;
  assign out_brightness = stg[DivStages].bright;

`ifndef SYNTHESIS
  // Saturation never exceeds one.
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= SatOne)
    else $error("saturation above one");

  // A black pixel has zero saturation and zero hue.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_saturation == '0 && out_hue == '0))
    else $error("black pixel with nonzero saturation or hue");

  // A result follows an item that was in the stage before the output.
  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n)) |-> $past(vld[DivStages-1]))
    else $error("result without a matching transaction");
`endif

endmodule

FILE: hw/rtl/rthsv_prep.sv
// First pipeline stage: value, chroma, hue sector numerator and divisor setup.
`timescale 1ns / 1ps

module rthsv_prep
  import rthsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [CompBits-1:0] in_red,
  input  logic [CompBits-1:0] in_green,
  input  logic [CompBits-1:0] in_blue,
  output logic                valid_r,
  output stage_t              stage_r
);

  logic [CompBits-1:0] v;
  logic [CompBits-1:0] lo;
  logic [CompBits-1:0] chroma;
  logic [DivBits-1:0]  c_ext;
  logic [DivBits-1:0]  six_c;
  logic [DivBits-1:0]  t;
  stage_t              stage_nxt;

  // Pick the sector; ties go to red, then green.
  always_comb begin
    lo = in_red;
    if (in_green < lo) begin
      lo = in_green;
    end
    if (in_blue < lo) begin
      lo = in_blue;
    end
    c_ext  = '0;
    six_c  = '0;
    chroma = '0;
    if (in_red >= in_green && in_red >= in_blue) begin
      v      = in_red;
      chroma = v - lo;
      c_ext  = DivBits'(chroma);
      six_c  = (c_ext << 2) + (c_ext << 1);
      // A negative difference wraps by one full turn.
      t = DivBits'(in_green) - DivBits'(in_blue) + ((in_green < in_blue) ? six_c : '0);
    end else if (in_green >= in_blue) begin
      v      = in_green;
      chroma = v - lo;
      c_ext  = DivBits'(chroma);
      six_c  = (c_ext << 2) + (c_ext << 1);
      t = DivBits'(in_blue) - DivBits'(in_red) + (c_ext << 1);
    end else begin
      v      = in_blue;
      chroma = v - lo;
      c_ext  = DivBits'(chroma);
      six_c  = (c_ext << 2) + (c_ext << 1);
      t = DivBits'(in_red) - DivBits'(in_green) + (c_ext << 2);
    end
  end

  // Set up both divisions; a zero divisor is replaced by one so the quotient is zero.
  always_comb begin
    stage_nxt.hue.rem     = RemBits'(t);
    stage_nxt.hue.divisor = (chroma == '0) ? DivBits'(1) : six_c;
    stage_nxt.hue.quo     = '0;
    // Saturation is chroma times 2^16 over twice the value.
    stage_nxt.sat.rem     = RemBits'(chroma);
    stage_nxt.sat.divisor = (v == '0) ? DivBits'(1) : (DivBits'(v) << 1);
    stage_nxt.sat.quo     = '0;
    stage_nxt.bright      = v;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    stage_r <= stage_nxt;
  end

endmodule

FILE: hw/rtl/rthsv_div_stage.sv
// One divider stage that advances the hue and saturation divisions by a few quotient bits.
`timescale 1ns / 1ps

module rthsv_div_stage
  import rthsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   valid_in,
  input  stage_t stage_in,
  output logic   valid_r,
  output stage_t stage_r
);

  stage_t stage_nxt;

  // Both divisions step in parallel.
  always_comb begin
    stage_nxt.hue    = div_step(stage_in.hue);
    stage_nxt.sat    = div_step(stage_in.sat);
    stage_nxt.bright = stage_in.bright;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    stage_r <= stage_nxt;
  end

endmodule

FILE: tb/sv/rgb_to_hsv_pixel_checker.sv
// Checker that predicts the HSV pixel for every accepted RGB transaction and compares the results.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_checker
  import rthsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [CompBits-1:0] in_red,
  input  logic [CompBits-1:0] in_green,
  input  logic [CompBits-1:0] in_blue,
  input  logic                out_valid,
  input  logic [QuoBits-1:0]  out_hue,
  input  logic [QuoBits-1:0]  out_saturation,
  input  logic [CompBits-1:0] out_brightness,
  output int                  fail_count,
  output int                  pending_pixels
);

  // One predicted HSV pixel, kept with the RGB pixel it came from for the log.
  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
    logic [QuoBits-1:0]  hue;
    logic [QuoBits-1:0]  sat;
    logic [CompBits-1:0] bright;
  } hsv_pixel_t;

  hsv_pixel_t expected_pixels[$];

  initial begin
    fail_count     = 0;
    pending_pixels = 0;
  end

  // Exact integer conversion: value, chroma, saturation and hue sector arithmetic.
  function automatic hsv_pixel_t predict_hsv(input logic [CompBits-1:0] r,
                                             input logic [CompBits-1:0] g,
                                             input logic [CompBits-1:0] b);
    hsv_pixel_t px;
    longint     v;
    longint     lo;
    longint     c;
    longint     t;
    v  = longint'(r);
    lo = longint'(r);
    if (longint'(g) > v) v = longint'(g);
    if (longint'(b) > v) v = longint'(b);
    if (longint'(g) < lo) lo = longint'(g);
    if (longint'(b) < lo) lo = longint'(b);
    c = v - lo;
    px.red    = r;
    px.green  = g;
    px.blue   = b;
    px.bright = v[CompBits-1:0];
    px.sat    = '0;
    px.hue    = '0;
    // A black pixel has no saturation.
    if (v != 0) begin
      px.sat = QuoBits'((c * longint'(SatOne)) / v);
    end
    // A gray pixel has no hue; ties on the largest go to red, then green.
    if (c != 0) begin
      if (v == longint'(r)) begin
        t = longint'(g) - longint'(b);
      end else if (v == longint'(g)) begin
        t = longint'(b) - longint'(r) + 2 * c;
      end else begin
        t = longint'(r) - longint'(g) + 4 * c;
      end
      // The red sector wraps below zero by one full turn.
      if (t < 0) begin
        t = t + 6 * c;
      end
      px.hue = QuoBits'((65536 * t) / (6 * c));
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Compare each result transaction with the oldest prediction, then record new pixels.
  always @(posedge clk) begin
    hsv_pixel_t want;
    if (!rst_n) begin
      expected_pixels.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result hue %0d sat %0d value %0d with no pixel outstanding",
                                    out_hue, out_saturation, out_brightness));
        end else begin
          want = expected_pixels.pop_front();
          if (out_hue !== want.hue) begin
            report_mismatch($sformatf("rgb (%0d,%0d,%0d) hue %0d, expected %0d",
                                      want.red, want.green, want.blue, out_hue, want.hue));
          end
          if (out_saturation !== want.sat) begin
            report_mismatch($sformatf("rgb (%0d,%0d,%0d) saturation %0d, expected %0d",
                                      want.red, want.green, want.blue, out_saturation,
                                      want.sat));
          end
          if (out_brightness !== want.bright) begin
            report_mismatch($sformatf("rgb (%0d,%0d,%0d) value %0d, expected %0d",
                                      want.red, want.green, want.blue, out_brightness,
                                      want.bright));
          end
        end
      end else if (out_valid !== 1'b0) begin
        report_mismatch("out_valid is unknown");
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_pixels.push_back(predict_hsv(in_red, in_green, in_blue));
      end
    end
    pending_pixels = expected_pixels.size();
  end

endmodule

FILE: tb/sv/rgb_to_hsv_converter_top_tb.sv
// Testbench top that drives RGB pixels into the converter and reports the verdict.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb
  import rthsv_pkg::*;
();

  localparam int HalfPeriod   = 5;
  localparam int RandomPixels = 850;
  localparam int DrainCycles  = 12;
  localparam int CycleLimit   = 200000;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CompBits-1:0] in_red   = '0;
  logic [CompBits-1:0] in_green = '0;
  logic [CompBits-1:0] in_blue  = '0;
  logic                out_valid;
  logic [QuoBits-1:0]  out_hue;
  logic [QuoBits-1:0]  out_saturation;
  logic [CompBits-1:0] out_brightness;
  int                  fail_count;
  int                  pending_pixels;
  int                  cycle_count = 0;

  always #HalfPeriod clk = ~clk;

  rgb_to_hsv_converter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  rgb_to_hsv_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("rgb_to_hsv_converter_top_tb: FAIL");
      $finish;
    end
  end

  // Present one pixel at a falling edge and hold it until a rising edge with busy low takes it.
  task automatic send_pixel(input logic [CompBits-1:0] r,
                            input logic [CompBits-1:0] g,
                            input logic [CompBits-1:0] b);
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    while (busy !== 1'b0) @(negedge clk);
    @(negedge clk);
  endtask

  // Idle cycles carry random data on the pixel ports with start low.
  task automatic idle_for(input int cycles);
    for (int i = 0; i < cycles; i++) begin
      start    <= 1'b0;
      in_red   <= CompBits'($urandom);
      in_green <= CompBits'($urandom);
      in_blue  <= CompBits'($urandom);
      @(negedge clk);
    end
  endtask

  // Mostly no gap or a short one, some long ones, none at all in quiet stretches.
  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [CompBits-1:0] extreme_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CompBits'(1);
      2: return {CompBits{1'b1}} - CompBits'(1);
      default: return {CompBits{1'b1}};
    endcase
  endfunction

  initial begin
    logic [CompBits-1:0] r;
    logic [CompBits-1:0] g;
    logic [CompBits-1:0] b;
    logic [CompBits-1:0] level;
    int                  roll;
    bit                  quiet;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pixels: black, white, gray, primaries, sector ties and red-sector wrap.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    idle_for(3);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd254);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd1,   8'd1,   8'd0);
    idle_for(1);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd200, 8'd10,  8'd100);
    send_pixel(8'hAA,  8'h55,  8'hFF);
    send_pixel(8'h55,  8'hFF,  8'hAA);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd2,   8'd1,   8'd2);

    // Random pixels in several shapes, with quiet and gappy stretches.
    quiet = 1'b0;
    for (int i = 0; i < RandomPixels; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        r = CompBits'($urandom);
        g = CompBits'($urandom);
        b = CompBits'($urandom);
      end else if (roll < 75) begin
        // Two components tie, the third is free.
        level = CompBits'($urandom);
        r = level;
        g = level;
        b = level;
        case ($urandom_range(0, 2))
          0: r = CompBits'($urandom);
          1: g = CompBits'($urandom);
          default: b = CompBits'($urandom);
        endcase
      end else if (roll < 85) begin
        // Nearly gray: tiny chroma.
        level = CompBits'($urandom_range(0, 250));
        r = level + CompBits'($urandom_range(0, 5));
        g = level + CompBits'($urandom_range(0, 5));
        b = level + CompBits'($urandom_range(0, 5));
      end else if (roll < 95) begin
        r = CompBits'($urandom_range(0, 3));
        g = CompBits'($urandom_range(0, 3));
        b = CompBits'($urandom_range(0, 3));
      end else begin
        r = extreme_level();
        g = extreme_level();
        b = extreme_level();
      end
      send_pixel(r, g, b);
      idle_for(pick_gap(quiet));
    end

    // Drain the pipeline and give the verdict.
    start <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("rgb_to_hsv_converter_top_tb: PASS");
    end else begin
      $display("rgb_to_hsv_converter_top_tb: FAIL");
    end
    $finish;
  end

endmodule
